@@ design/tqs_pkg.sv @@
package tqs_pkg;

  localparam int CAP_W    = 16;
  localparam int PERIOD_W = 17;
  localparam int SCALE_W  = 31;
  localparam int SPEED_W  = 32;
  localparam int DIV_W    = 32;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);

  localparam logic [1:0] KIND_EDGE     = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;

  localparam logic REG_SPEED_SCALE = 1'b0;
  localparam logic REG_COUNTER_TOP = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 31'd1000000;
  localparam logic [CAP_W-1:0]   TOP_RESET   = 16'd12000;
  localparam logic [SCALE_W-1:0] MAG_SAT     = {SCALE_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_EDGE,
    CMD_GAP,
    CMD_TICK
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [CAP_W-1:0] cap;
    logic             rev;
  } q_entry_t;

  typedef struct packed {
    dir_t                dir;
    logic [PERIOD_W-1:0] period;
  } ring_entry_t;

  typedef struct packed {
    logic [SCALE_W-1:0] speed_scale;
    logic [CAP_W-1:0]   counter_top;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic {
    DV_IDLE,
    DV_RUN
  } div_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_A,
    S_MOD_B,
    S_SWEEP,
    S_DRAIN,
    S_CHECK,
    S_DIV,
    S_EMIT
  } back_state_t;

endpackage

@@ design/tqs_if.sv @@
interface tqs_in_if;
  import tqs_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [CAP_W-1:0] capture_value;
  logic             second_channel_high;

  modport source (output valid, output kind, output capture_value,
                  output second_channel_high, input ready);
  modport sink   (input valid, input kind, input capture_value,
                  input second_channel_high, output ready);
endinterface

interface tqs_out_if;
  import tqs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed;

  modport source (output valid, output speed, input ready);
  modport sink   (input valid, input speed, output ready);
endinterface

@@ design/tqs_fifo.sv @@
module tqs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tqs_pkg::q_entry_t  push_data,
  output logic               full,
  input  logic               pop,
  output tqs_pkg::q_entry_t  head,
  output logic               empty
);
  import tqs_pkg::*;

  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr_r;
  logic [Q_PTR_W-1:0]     rd_ptr_r;
  logic [Q_CNT_W-1:0]     count_r;
  logic [Q_CNT_W-1:0]     count_nxt;

  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/tqs_front.sv @@
module tqs_front (
  input  logic              clk,
  input  logic              rst_n,
  tqs_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output tqs_pkg::q_entry_t q_data
);
  import tqs_pkg::*;

  logic forgiven_r;
  logic forgiven_nxt;
  logic accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_push       = 1'b0;
    forgiven_nxt = forgiven_r;
    q_data.cmd   = CMD_TICK;
    q_data.cap   = in_ch.capture_value;
    q_data.rev   = in_ch.second_channel_high;
    if (accept) begin
      unique case (in_ch.kind)
        KIND_EDGE: begin
          q_push       = 1'b1;
          q_data.cmd   = CMD_EDGE;
          forgiven_nxt = 1'b0;
        end
        KIND_OVERFLOW: begin
          // first overflow after an edge is forgiven
          if (forgiven_r) begin
            q_push     = 1'b1;
            q_data.cmd = CMD_GAP;
          end else begin
            forgiven_nxt = 1'b1;
          end
        end
        KIND_TICK: begin
          q_push     = 1'b1;
          q_data.cmd = CMD_TICK;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forgiven_r <= 1'b0;
    end else begin
      forgiven_r <= forgiven_nxt;
    end
  end

endmodule

@@ design/tqs_div.sv @@
module tqs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tqs_pkg::div_req_t req,
  output tqs_pkg::div_rsp_t rsp
);
  import tqs_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

  div_state_t         state_r;
  div_state_t         state_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [DIV_W-1:0]   rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [DIV_W-1:0]   dsr_r;
  logic               done_r;
  logic               load;
  logic               last_step;
  logic [DIV_W:0]     trial;
  logic [DIV_W-1:0]   rem_nxt;

  assign trial   = {rem_r, quo_r[DIV_W-1]} - {1'b0, dsr_r};
  assign rem_nxt = trial[DIV_W] ? {rem_r[DIV_W-2:0], quo_r[DIV_W-1]} : trial[DIV_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        if (step_r == LAST_STEP) begin
          state_nxt = DV_IDLE;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    last_step = 1'b0;
    unique case (state_r)
      DV_IDLE: load      = req.start;
      DV_RUN:  last_step = (step_r == LAST_STEP);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= last_step;
      if (load) begin
        step_r <= '0;
      end else if (state_r == DV_RUN) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (state_r == DV_RUN) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], !trial[DIV_W]};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

@@ design/tqs_back.sv @@
module tqs_back #(
  parameter int RING_DEPTH = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tqs_pkg::cfg_t     cfg,
  input  tqs_pkg::q_entry_t q_head,
  input  logic              q_empty,
  output logic              q_pop,
  tqs_out_if.source         out_ch
);
  import tqs_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = PERIOD_W + $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  back_state_t          state_r;
  back_state_t          state_nxt;
  q_entry_t             cmd_r;
  logic [CAP_W-1:0]     last_cap_r;
  logic [IDX_W-1:0]     wr_slot_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [RING_DEPTH-1:0] valid_r;
  ring_entry_t          ring_mem [RING_DEPTH];
  ring_entry_t          rd_data_r;
  logic                 rd_valid_r;
  logic                 rd_pend_r;
  logic [PERIOD_W-1:0]  mod_a_r;
  logic [SUM_W-1:0]     sum_r;
  logic [CNT_W-1:0]     rev_cnt_r;
  logic                 none_r;
  logic [SCALE_W-1:0]   mag_r;
  logic                 out_vld_r;
  logic [SPEED_W-1:0]   speed_r;

  logic [PERIOD_W-1:0]  modulus;
  logic [PERIOD_W-1:0]  mod_b;
  logic [PERIOD_W-1:0]  period;
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic                 mem_we;
  ring_entry_t          mem_wdata;
  logic                 rd_issue;
  logic                 tick_start;
  logic                 emit;
  logic                 vote_pos;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign modulus = PERIOD_W'(cfg.counter_top) + PERIOD_W'(1);
  assign mod_b   = div_rsp.remainder[PERIOD_W-1:0];
  assign period  = (mod_a_r >= mod_b) ? (mod_a_r - mod_b) : (mod_a_r + modulus - mod_b);

  assign div_req.start    = div_start;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = (state_r == S_CHECK) ? DIV_W'(sum_r) : DIV_W'(modulus);

  tqs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.cmd)
            CMD_EDGE: state_nxt = S_MOD_A;
            CMD_TICK: state_nxt = S_SWEEP;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_MOD_A: if (div_rsp.done) state_nxt = S_MOD_B;
      S_MOD_B: if (div_rsp.done) state_nxt = S_IDLE;
      S_SWEEP: if (rd_idx_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_CHECK;
      S_CHECK: state_nxt = (none_r || sum_r == '0) ? S_EMIT : S_DIV;
      S_DIV:   if (div_rsp.done) state_nxt = S_EMIT;
      S_EMIT:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    q_pop            = 1'b0;
    div_start        = 1'b0;
    div_dividend     = DIV_W'(cfg.speed_scale);
    mem_we           = 1'b0;
    mem_wdata.dir    = DIR_NONE;
    mem_wdata.period = '0;
    rd_issue         = 1'b0;
    tick_start       = 1'b0;
    emit             = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_head.cmd)
            CMD_EDGE: begin
              div_start    = 1'b1;
              div_dividend = DIV_W'(q_head.cap);
            end
            CMD_GAP:  mem_we     = 1'b1;
            CMD_TICK: tick_start = 1'b1;
            default: begin
            end
          endcase
        end
      end
      S_MOD_A: begin
        if (div_rsp.done) begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(last_cap_r);
        end
      end
      S_MOD_B: begin
        if (div_rsp.done) begin
          mem_we           = 1'b1;
          mem_wdata.dir    = cmd_r.rev ? DIR_REV : DIR_FWD;
          mem_wdata.period = period;
        end
      end
      S_SWEEP: rd_issue  = 1'b1;
      S_CHECK: div_start = !none_r && (sum_r != '0);
      S_EMIT:  emit      = !out_vld_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wr_slot_r <= '0;
      valid_r   <= '0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
      last_cap_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_issue;
      if (mem_we) begin
        valid_r[wr_slot_r] <= 1'b1;
        wr_slot_r <= (wr_slot_r == LAST_IDX) ? '0 : wr_slot_r + 1'b1;
      end
      if (state_r == S_MOD_B && div_rsp.done) begin
        last_cap_r <= cmd_r.cap;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_slot_r] <= mem_wdata;
    end
    rd_data_r  <= ring_mem[rd_idx_r];
    rd_valid_r <= valid_r[rd_idx_r];
  end

  assign vote_pos = ({rev_cnt_r, 1'b0} < (CNT_W + 1)'(RING_DEPTH));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (state_r == S_MOD_A && div_rsp.done) begin
      mod_a_r <= div_rsp.remainder[PERIOD_W-1:0];
    end
    if (tick_start) begin
      sum_r     <= '0;
      rev_cnt_r <= '0;
      none_r    <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      if (rd_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (rd_pend_r) begin
        sum_r <= sum_r + SUM_W'(rd_data_r.period);
        if (!rd_valid_r || rd_data_r.dir == DIR_NONE) begin
          none_r <= 1'b1;
        end
        if (rd_valid_r && rd_data_r.dir == DIR_REV) begin
          rev_cnt_r <= rev_cnt_r + 1'b1;
        end
      end
    end
    if (state_r == S_CHECK) begin
      if (none_r) begin
        mag_r <= '0;
      end else if (sum_r == '0) begin
        mag_r <= MAG_SAT;
      end
    end
    if (state_r == S_DIV && div_rsp.done) begin
      mag_r <= div_rsp.quotient[SCALE_W-1:0];
    end
    if (emit) begin
      speed_r <= vote_pos ? {1'b0, mag_r} : (SPEED_W'(0) - {1'b0, mag_r});
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.speed = $signed(speed_r);

endmodule

@@ design/quadrature_tachometer_speed.sv @@
// channel   dir  transfer when             payload
// in_ch     in   valid && ready            kind, capture_value, second_channel_high
// out_ch    out  valid && ready            speed
// apb       in   psel && penable && pwrite speed_scale @0x0, counter_top @0x4
//
// an encoder edge runs two 32-step divider passes in the back end, which
// reduce the two capture values modulo counter_top + 1
// a tick reads one ring entry per cycle, then divides unless an entry is empty or sum is 0
// stored overflows are written as popped; forgiven ones and unused kinds never reach the back
// a four-entry queue lets input transfers continue while the back end or the output stalls
// synchronous active-low reset clears the ring valid bits, pointers and handshake state
module quadrature_tachometer_speed #(
  parameter int RING_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  tqs_in_if.sink      in_ch,
  tqs_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tqs_pkg::*;

  logic [SCALE_W-1:0] scale_r;
  logic [CAP_W-1:0]   top_r;
  logic               cfg_wr;
  cfg_t               cfg;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  q_entry_t           q_wdata;
  q_entry_t           q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_COUNTER_TOP) ? {16'd0, top_r} : {1'b0, scale_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      top_r   <= TOP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SPEED_SCALE) begin
        scale_r <= pwdata[SCALE_W-1:0];
      end else begin
        top_r <= pwdata[CAP_W-1:0];
      end
    end
  end

  assign cfg.speed_scale = scale_r;
  assign cfg.counter_top = top_r;

  tqs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  tqs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  tqs_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("queue push while full");

  a_queue_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty)) else $error("queue pop while empty");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("result valid right after reset");
`endif

endmodule

@@ tb/sv/tb_quadrature_tachometer_speed.sv @@
`timescale 1ns / 100ps

module tb_quadrature_tachometer_speed;
  import tqs_pkg::*;

  localparam int RING_DEPTH = 10;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 1200;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CAP_W-1:0] cap;
    logic             rev;
  } enc_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  tqs_in_if in_ch ();
  tqs_out_if out_ch ();

  quadrature_tachometer_speed #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // speed predictor state
  logic [SCALE_W-1:0]  scale_cfg = SCALE_RESET;
  logic [CAP_W-1:0]    top_cfg = TOP_RESET;
  logic [PERIOD_W-1:0] ring_period [RING_DEPTH] = '{default: '0};
  dir_t                ring_dir [RING_DEPTH] = '{default: DIR_NONE};
  int                  ring_slot = 0;
  logic [CAP_W-1:0]    prev_capture = '0;
  logic                overflow_pardoned = 1'b0;

  logic signed [SPEED_W-1:0] speed_expect [$];
  enc_item_t pending_items [$];

  int err_count = 0;
  int in_count = 0;
  int speed_checked = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_served = 0;
  int hold_left = 0;
  int gen_pos = 0;
  logic lean_rev = 1'b0;
  logic in_fired = 1'b0;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic logic [PERIOD_W-1:0] wrap_ticks(logic [CAP_W-1:0] now_cap,
                                                     logic [CAP_W-1:0] old_cap);
    logic [PERIOD_W-1:0] modulus, a, b;
    modulus = top_cfg + 17'd1;
    a = now_cap % modulus;
    b = old_cap % modulus;
    return (a >= b) ? a - b : a + modulus - b;
  endfunction

  task automatic store_entry(logic [PERIOD_W-1:0] period, dir_t dir);
    ring_period[ring_slot] = period;
    ring_dir[ring_slot] = dir;
    ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
  endtask

  function automatic logic signed [SPEED_W-1:0] speed_now();
    logic [31:0] total;
    logic [31:0] mag;
    int vote;
    total = '0;
    vote = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (ring_dir[i] == DIR_NONE) return '0;
      total += 32'(ring_period[i]);
      vote += (ring_dir[i] == DIR_REV) ? -1 : 1;
    end
    mag = (total == 0) ? {1'b0, MAG_SAT} : {1'b0, scale_cfg} / total;
    return (vote > 0) ? mag : -mag;
  endfunction

  task automatic apply_transfer(logic [1:0] kind, logic [CAP_W-1:0] cap, logic rev);
    case (kind)
      KIND_EDGE: begin
        store_entry(wrap_ticks(cap, prev_capture), rev ? DIR_REV : DIR_FWD);
        overflow_pardoned = 1'b0;
        prev_capture = cap;
      end
      KIND_OVERFLOW: begin
        if (!overflow_pardoned) overflow_pardoned = 1'b1;
        else store_entry('0, DIR_NONE);
      end
      KIND_TICK: speed_expect.push_back(speed_now());
      default: ;
    endcase
  endtask

  // input driver
  always @(negedge clk) begin : drive_in
    enc_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= nxt.kind;
        in_ch.capture_value <= nxt.cap;
        in_ch.second_channel_high <= nxt.rev;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin : watch
    logic signed [SPEED_W-1:0] want;
    if (!rst_n) begin
      in_fired <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        apply_transfer(in_ch.kind, in_ch.capture_value, in_ch.second_channel_high);
        in_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (speed_expect.size() == 0) begin
          report_mismatch($sformatf("speed %0d with no tick pending", out_ch.speed));
        end else begin
          want = speed_expect.pop_front();
          if (out_ch.speed !== want)
            report_mismatch($sformatf("speed got %0d want %0d", out_ch.speed, want));
          speed_checked++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_quadrature_tachometer_speed: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic cfg_write(logic reg_idx, logic [31:0] value);
    logic [31:0] want;
    want = (reg_idx == REG_SPEED_SCALE) ? {1'b0, value[SCALE_W-1:0]} : {16'd0, value[15:0]};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d reads %0h want %0h", reg_idx, prdata, want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == REG_SPEED_SCALE) scale_cfg = value[SCALE_W-1:0];
    else top_cfg = value[15:0];
  endtask

  task automatic queue_item(logic [1:0] kind, logic [CAP_W-1:0] cap, logic rev);
    enc_item_t it;
    it.kind = kind;
    it.cap = cap;
    it.rev = rev;
    pending_items.push_back(it);
  endtask

  // mostly edges with a drifting direction lean, some overflows, ticks and unused kinds
  task automatic queue_random(int n);
    int made;
    int r;
    logic [CAP_W-1:0] cap;
    logic rev;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) lean_rev = ~lean_rev;
      rev = ($urandom_range(0, 5) == 0) ? 1'($urandom_range(0, 1)) : lean_rev;
      if (r < 55) begin
        case ($urandom_range(0, 2))
          0: cap = CAP_W'($urandom);
          1: cap = CAP_W'($urandom_range(0, top_cfg));
          default: cap = CAP_W'((gen_pos + $urandom_range(0, 7)) % (top_cfg + 1));
        endcase
        gen_pos = int'(cap);
        queue_item(KIND_EDGE, cap, rev);
        made++;
      end else if (r < 62) begin
        queue_item(KIND_OVERFLOW, CAP_W'($urandom), rev);
        made++;
        if ($urandom_range(0, 2) == 0) begin
          queue_item(KIND_OVERFLOW, CAP_W'($urandom), rev);
          made++;
        end
      end else if (r < 88) begin
        queue_item(KIND_TICK, CAP_W'($urandom), rev);
        made++;
      end else if (r < 93) begin
        queue_item(KIND_UNUSED, CAP_W'($urandom), rev);
      end else begin
        queue_item(KIND_EDGE, CAP_W'(gen_pos), rev);
        made++;
      end
    end
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || in_ch.valid || speed_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] scale, logic [31:0] top, int send_pct, int recv_pct,
                           bit pressure, int n);
    settle();
    cfg_write(REG_SPEED_SCALE, scale);
    cfg_write(REG_COUNTER_TOP, top);
    settings_used++;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (pressure) hold_request++;
    queue_random(n);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_EDGE;
    in_ch.capture_value = '0;
    in_ch.second_channel_high = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty ring, unused kind, zero period sum with a direction tie
    queue_item(KIND_TICK, 16'd0, 1'b0);
    queue_item(KIND_UNUSED, 16'hffff, 1'b1);
    for (int i = 0; i < RING_DEPTH; i++) queue_item(KIND_EDGE, 16'd0, i[0]);
    queue_item(KIND_TICK, 16'd0, 1'b0);
    // capture beyond the top, forgiven then stored overflow, counter wrap
    queue_item(KIND_EDGE, 16'hffff, 1'b0);
    queue_item(KIND_OVERFLOW, 16'd0, 1'b0);
    queue_item(KIND_OVERFLOW, 16'd0, 1'b0);
    queue_item(KIND_TICK, 16'd0, 1'b0);
    queue_item(KIND_EDGE, TOP_RESET, 1'b1);
    queue_item(KIND_EDGE, 16'd5, 1'b0);
    queue_item(KIND_TICK, 16'd0, 1'b0);
    gen_pos = 5;

    run_phase(32'h7fffffff, 32'd65535, 0, 0, 1'b0, 115);
    run_phase(32'd1, 32'd1, 81, 0, 1'b0, 115);
    run_phase(32'd0, 32'd300, 0, 81, 1'b0, 115);
    run_phase(32'd1000000, 32'd12000, 31, 31, 1'b0, 115);
    run_phase($urandom_range(1, 32'h7fffffff), $urandom_range(2, 2000), 0, 0, 1'b1, 115);
    run_phase($urandom, $urandom_range(1, 65535), 31, 31, 1'b0, 115);
    settle();

    while (speed_expect.size() != 0)
      report_mismatch($sformatf("tick result %0d never arrived", speed_expect.pop_front()));
    $display("run covered %0d input transfers and %0d speed results", in_count, speed_checked);
    $display("over %0d register settings and four idling patterns", settings_used);
    if (err_count == 0) begin
      $display("tb_quadrature_tachometer_speed: clean");
    end else begin
      $display("tb_quadrature_tachometer_speed: errors");
    end
    $finish;
  end

endmodule

@@ quadrature_tachometer_speed.f @@
design/tqs_pkg.sv
design/tqs_if.sv
design/tqs_fifo.sv
design/tqs_front.sv
design/tqs_div.sv
design/tqs_back.sv
design/quadrature_tachometer_speed.sv
tb/sv/tb_quadrature_tachometer_speed.sv
